>>> src/pitf_pkg.sv
// shared types and constants for the section filter table
`timescale 1ns / 1ps

package pitf_pkg;

   // table geometry
   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   // command queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // request operation codes
   localparam logic [2:0] OP_ADD   = 3'd0;
   localparam logic [2:0] OP_DEL   = 3'd1;
   localparam logic [2:0] OP_MATCH = 3'd2;
   localparam logic [2:0] OP_ON    = 3'd3;
   localparam logic [2:0] OP_OFF   = 3'd4;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [2:0]  operation;
      logic [12:0] stream_id;
      logic [7:0]  table_id;
      logic [7:0]  id_mask;
      logic        keep_when_off;
   } req_type;

   typedef struct packed {
      logic       matched;
      logic [1:0] status;
      logic       filter_on;
      logic [4:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic        sticky;
      logic [7:0]  id_mask;
      logic [7:0]  table_id;
      logic [12:0] stream_id;
   } entry_type;

   typedef enum logic [2:0] {
      CMD_ADD,
      CMD_DEL,
      CMD_MATCH,
      CMD_ON,
      CMD_OFF,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [12:0]  stream_id;
      logic [7:0]   table_id;
      logic [7:0]   id_mask;
      logic         keep_when_off;
   } cmd_type;

   // handshake between front queue and back engine
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

   typedef enum logic {
      BK_RUN,
      BK_PURGE
   } back_state_type;

endpackage

>>> src/pid_table_id_filter_table_core.sv
// top level of the section filter table: stream id / table id filter entries
`timescale 1ns / 1ps

// usage
// - requests go in through req_push / req_full with the fields in req_item;
//   an item is taken on a clock edge with req_push high and req_full low
// - every request gives exactly one result on rsp_item, shown while
//   rsp_empty is low and taken on an edge with rsp_pop high
// - csr_we / csr_wdata write the handler-attached bit; write it only while
//   no request is in flight
// - the front decodes each item into a two-deep command queue; the back
//   executes one command per cycle, when not purging and the output is free,
//   against all entries in parallel and holds the result in one output
//   register that refills on the same edge it is popped
// - an item is registered in the command queue, and its result then in the output register
// - throughput: one item per cycle while results are popped, except a switch
//   off that really turns the filter off: it waits while the purge drops each
//   non-sticky entry, then loads its result (the purge shifts out one entry per cycle)
// - a stalled receiver fills the output register, then the queue, and then
//   raises req_full; nothing is dropped
// - reset empties the table, turns the filter off and clears the
//   handler-attached bit; entry storage itself is not cleared
module pid_table_id_filter_table_core (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_push,
   output logic              req_full,
   input  pitf_pkg::req_type req_item,
   // result channel
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output pitf_pkg::rsp_type rsp_item,
   // handler-attached register
   input  logic              csr_we,
   input  logic              csr_wdata
);

   // command path from decode queue to engine
   pitf_pkg::cmd_chan_type cmd_chan;
   logic                   cmd_pop;

   // front: decode and buffer
   pitf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .cmd_out  (cmd_chan),
      .cmd_pop  (cmd_pop)
   );

   // back: table, compare lanes, compaction, result register
   pitf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd_in    (cmd_chan),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule

>>> src/pitf_front.sv
// request decode and command queue feeding the execution engine
`timescale 1ns / 1ps

module pitf_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  pitf_pkg::req_type      req_item,
   output pitf_pkg::cmd_chan_type cmd_out,
   input  logic                   cmd_pop
);

   pitf_pkg::cmd_type            slot_ff [pitf_pkg::QDEPTH];
   logic [pitf_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [pitf_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [pitf_pkg::QCNT_W-1:0]  cnt_ff, cnt_in;
   pitf_pkg::cmd_type            decoded;
   logic                         push_ok;
   logic                         pop_ok;

   // classify the operation code
   always_comb begin
      decoded.stream_id     = req_item.stream_id;
      decoded.table_id      = req_item.table_id;
      decoded.id_mask       = req_item.id_mask;
      decoded.keep_when_off = req_item.keep_when_off;
      case (req_item.operation)
         pitf_pkg::OP_ADD:   decoded.kind = pitf_pkg::CMD_ADD;
         pitf_pkg::OP_DEL:   decoded.kind = pitf_pkg::CMD_DEL;
         pitf_pkg::OP_MATCH: decoded.kind = pitf_pkg::CMD_MATCH;
         pitf_pkg::OP_ON:    decoded.kind = pitf_pkg::CMD_ON;
         pitf_pkg::OP_OFF:   decoded.kind = pitf_pkg::CMD_OFF;
         default:            decoded.kind = pitf_pkg::CMD_NOP;
      endcase
   end

   assign req_full      = (cnt_ff == pitf_pkg::QCNT_W'(pitf_pkg::QDEPTH));
   assign push_ok       = req_push && !req_full;
   assign pop_ok        = cmd_pop && cmd_out.valid;
   assign cmd_out.valid = (cnt_ff != '0);
   assign cmd_out.cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == pitf_pkg::QPTR_W'(pitf_pkg::QDEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == pitf_pkg::QPTR_W'(pitf_pkg::QDEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

>>> src/pitf_back.sv
// execution engine: entry table, parallel compare, compaction and result register
`timescale 1ns / 1ps

module pitf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic                   csr_wdata,
   input  pitf_pkg::cmd_chan_type cmd_in,
   output logic                   cmd_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output pitf_pkg::rsp_type      rsp_item
);

   pitf_pkg::entry_type          entries_ff [pitf_pkg::ENTRIES];
   logic [pitf_pkg::CNT_W-1:0]   count_ff, count_in;
   logic                         on_ff, on_in;
   logic                         handler_ff;
   pitf_pkg::back_state_type     state_ff, state_in;
   logic                         rsp_valid_ff;
   pitf_pkg::rsp_type            rsp_data_ff, rsp_next;
   logic                         rsp_load;

   logic [pitf_pkg::ENTRIES-1:0] lane_valid, del_vec, match_vec, purge_vec;
   logic [pitf_pkg::ENTRIES-1:0] rm_vec, shift_vec;
   logic                         any_rm;
   logic                         out_free;
   logic                         fire;
   logic                         shift_en;
   logic                         append_en;
   logic                         has_room;
   pitf_pkg::cmd_type            cmd;
   pitf_pkg::entry_type          new_entry;

   assign cmd       = cmd_in.cmd;
   assign out_free  = !rsp_valid_ff || rsp_pop;
   assign fire      = (state_ff == pitf_pkg::BK_RUN) && cmd_in.valid && out_free;
   assign has_room  = (count_ff < pitf_pkg::CNT_W'(pitf_pkg::ENTRIES));
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_item  = rsp_data_ff;

   assign new_entry.sticky    = cmd.keep_when_off;
   assign new_entry.id_mask   = cmd.id_mask;
   assign new_entry.table_id  = cmd.table_id;
   assign new_entry.stream_id = cmd.stream_id;

   // per-lane compares against every held entry
   always_comb begin
      for (int i = 0; i < pitf_pkg::ENTRIES; i++) begin
         lane_valid[i] = (pitf_pkg::CNT_W'(i) < count_ff);
         del_vec[i]    = lane_valid[i]
                         && (entries_ff[i].stream_id == cmd.stream_id)
                         && (entries_ff[i].table_id == cmd.table_id)
                         && (entries_ff[i].id_mask == cmd.id_mask);
         match_vec[i]  = lane_valid[i]
                         && (entries_ff[i].stream_id == cmd.stream_id)
                         && (entries_ff[i].table_id ==
                             (cmd.table_id & entries_ff[i].id_mask));
         purge_vec[i]  = lane_valid[i] && !entries_ff[i].sticky;
      end
   end

   // first hit and every slot at or after it moves down one place
   always_comb begin
      rm_vec = (state_ff == pitf_pkg::BK_PURGE) ? purge_vec : del_vec;
      for (int i = 0; i < pitf_pkg::ENTRIES; i++) begin
         shift_vec[i] = |(rm_vec & ((pitf_pkg::ENTRIES'(1) << i) << 1)
                          - pitf_pkg::ENTRIES'(1)) == 1'b0 ? 1'b0 : 1'b1;
      end
      any_rm = |rm_vec;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pitf_pkg::BK_RUN: begin
            if (fire && (cmd.kind == pitf_pkg::CMD_OFF) && handler_ff && on_ff) begin
               state_in = pitf_pkg::BK_PURGE;
            end
         end
         pitf_pkg::BK_PURGE: begin
            if (!any_rm && out_free) begin
               state_in = pitf_pkg::BK_RUN;
            end
         end
         default: state_in = pitf_pkg::BK_RUN;
      endcase
   end

   // engine outputs
   always_comb begin
      cmd_pop   = 1'b0;
      shift_en  = 1'b0;
      append_en = 1'b0;
      rsp_load  = 1'b0;
      on_in     = on_ff;
      count_in  = count_ff;
      rsp_next  = '0;
      case (state_ff)
         pitf_pkg::BK_RUN: begin
            if (fire) begin
               cmd_pop  = 1'b1;
               rsp_load = 1'b1;
               case (cmd.kind)
                  pitf_pkg::CMD_ADD: begin
                     if (has_room) begin
                        append_en       = 1'b1;
                        count_in        = count_ff + 1'b1;
                        rsp_next.status = pitf_pkg::ST_OK;
                     end else begin
                        rsp_next.status = pitf_pkg::ST_FULL;
                     end
                  end
                  pitf_pkg::CMD_DEL: begin
                     if (any_rm) begin
                        shift_en        = 1'b1;
                        count_in        = count_ff - 1'b1;
                        rsp_next.status = pitf_pkg::ST_OK;
                     end else begin
                        rsp_next.status = pitf_pkg::ST_NOT_FOUND;
                     end
                  end
                  pitf_pkg::CMD_MATCH: begin
                     rsp_next.matched = on_ff && (|match_vec);
                  end
                  pitf_pkg::CMD_ON: begin
                     if (handler_ff) begin
                        on_in = 1'b1;
                     end
                  end
                  pitf_pkg::CMD_OFF: begin
                     // real switch off: result waits for the purge to finish
                     if (handler_ff && on_ff) begin
                        on_in    = 1'b0;
                        rsp_load = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         pitf_pkg::BK_PURGE: begin
            if (any_rm) begin
               shift_en = 1'b1;
               count_in = count_ff - 1'b1;
            end else if (out_free) begin
               rsp_load        = 1'b1;
               rsp_next.status = pitf_pkg::ST_OK;
            end
         end
         default: begin
         end
      endcase
      rsp_next.filter_on   = on_in;
      rsp_next.entry_count = 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pitf_pkg::BK_RUN;
         count_ff     <= '0;
         on_ff        <= 1'b0;
         handler_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         on_ff    <= on_in;
         if (csr_we) begin
            handler_ff <= csr_wdata;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (append_en) begin
         entries_ff[count_ff[pitf_pkg::IDX_W-1:0]] <= new_entry;
      end else if (shift_en) begin
         for (int i = 0; i < pitf_pkg::ENTRIES - 1; i++) begin
            if (shift_vec[i]) begin
               entries_ff[i] <= entries_ff[i + 1];
            end
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pitf_pkg::CNT_W'(pitf_pkg::ENTRIES))
      else $error("entry count beyond table size");

   a_purge_off: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pitf_pkg::BK_PURGE) |-> !on_ff)
      else $error("purge running while filter on");

   a_shift_nonempty: assert property (@(posedge clock) disable iff (reset)
      shift_en |-> (count_ff != '0) && !append_en)
      else $error("removal from empty table");

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (fire && (cmd.kind == pitf_pkg::CMD_ADD) && has_room)
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("add did not grow the table");

endmodule
